/* src/itsu_pkg.sv */
package itsu_pkg;

    // Field widths of the text and result channels
    localparam int BYTE_W  = 8;
    localparam int MAG_W   = 64;

    // Configuration register widths
    localparam int BASE_W  = 6;
    localparam int LIMIT_W = 8;
    localparam int DATA_W  = 8;
    localparam int INDEX_W = 1;

    // Configuration register indexes
    localparam logic [INDEX_W-1:0] REG_BASE_MODE = 1'd0;
    localparam logic [INDEX_W-1:0] REG_MAX_WIDTH = 1'd1;

    // Digit value of a byte that is no digit at all
    localparam int DIGIT_W = 7;
    localparam logic [DIGIT_W-1:0] NOT_A_DIGIT = 7'd64;

    // Characters with a role of their own
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'h0b;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0c;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_B  = 8'h42;
    localparam logic [BYTE_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5a;
    localparam logic [BYTE_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LO_B  = 8'h62;
    localparam logic [BYTE_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [BYTE_W-1:0] CH_LO_Z  = 8'h7a;

    // Bases that the prefix logic treats specially
    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_BIN  = 6'd2;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    function automatic logic blank_byte(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_value(input logic [BYTE_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        d = NOT_A_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = DIGIT_W'(c - CH_ZERO);
        end
        else if (c >= CH_LO_A && c <= CH_LO_Z)
        begin
            d = DIGIT_W'(c - CH_LO_A) + DIGIT_W'(10);
        end
        else if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            d = DIGIT_W'(c - CH_UP_A) + DIGIT_W'(10);
        end
        return d;
    endfunction

endpackage

/* src/itsu_if.sv */
// Text channel: one byte of the stream per word
interface itsu_text_if;
    logic                        valid;
    logic                        ready;
    logic [itsu_pkg::BYTE_W-1:0] byte_in;
    logic                        end_of_input;

    modport source (output valid, output byte_in, output end_of_input, input ready);
    modport sink   (input valid, input byte_in, input end_of_input, output ready);
endinterface

// Result channel: one verdict per text word
interface itsu_result_if;
    logic                       valid;
    logic                       ready;
    logic                       taken;
    logic                       done_res;
    logic                       invalid;
    logic                       negative;
    logic [itsu_pkg::MAG_W-1:0] magnitude;

    modport source (output valid, output taken, output done_res, output invalid,
                    output negative, output magnitude, input ready);
    modport sink   (input valid, input taken, input done_res, input invalid,
                    input negative, input magnitude, output ready);
endinterface

/* src/integer_text_scanner_unit.sv */
// Integer text scanner.
// The text channel carries one stream byte per word (or an end-of-input
// mark); the result channel returns exactly one word for each text word.
// taken says whether the byte was consumed: if not, the source presents the
// same byte again. done_res closes a number and then carries invalid,
// negative and the 64-bit magnitude; the scanner then starts over on the
// next number. base_mode and max_width are written through wr_en, wr_index
// and wr_data; the user must do so only while the scanner is idle, as the
// block itself does not enforce it. A text word is registered at the input;
// its result is then loaded into the output register and offered from there.
// Throughput: one word per cycle while the result port is not stalled, set
// by the single multiply-add step on the registered accumulator.
// A stalled result port holds the output register; the input register still
// takes one more word if it is empty, then text.ready drops until the result
// is taken. Reset clears the valid flags of both registers, the scan state
// and the configuration (base_mode 0, max_width 0).
module integer_text_scanner_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    itsu_text_if.sink                         text,
    itsu_result_if.source                     result,
    input  logic                              wr_en,
    input  logic [itsu_pkg::INDEX_W-1:0]      wr_index,
    input  logic [itsu_pkg::DATA_W-1:0]       wr_data
);

    typedef enum logic [3:0] {
        PH_SKIP       = 4'b0001,
        PH_PREFIX     = 4'b0010,
        PH_AFTER_ZERO = 4'b0100,
        PH_DIGITS     = 4'b1000
    } phase_t;

    localparam int MAG_W   = itsu_pkg::MAG_W;
    localparam int BASE_W  = itsu_pkg::BASE_W;
    localparam int LIMIT_W = itsu_pkg::LIMIT_W;
    localparam int PROD_W  = MAG_W + BASE_W;
    localparam logic [LIMIT_W-1:0] COUNT_MAX = '1;

    // Configuration
    logic [BASE_W-1:0]  base_mode_reg;
    logic [LIMIT_W-1:0] max_width_reg;

    // Input register
    logic                        in_valid_reg;
    logic [itsu_pkg::BYTE_W-1:0] byte_reg;
    logic                        eoi_reg;

    // Scan state
    phase_t             phase_reg, phase_next;
    logic [MAG_W-1:0]   acc_reg, acc_next;
    logic [LIMIT_W-1:0] count_reg, count_next;
    logic [BASE_W-1:0]  wbase_reg, wbase_next;
    logic               saw_reg, saw_next;
    logic               minus_reg, minus_next;

    // Output register
    logic               out_valid_reg;
    logic               taken_reg, taken_next;
    logic               done_reg, done_next;
    logic               invalid_reg, invalid_next;
    logic               negative_reg, negative_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;

    logic               out_free;
    logic               advance;
    logic [PROD_W-1:0]  prod_full;
    logic [MAG_W-1:0]   prod;

    assign out_free   = !out_valid_reg || result.ready;
    assign advance    = in_valid_reg && out_free;
    assign text.ready = !in_valid_reg || advance;

    // Accumulator is zero outside the digit phase, so the held base is enough
    assign prod_full = PROD_W'(acc_reg) * PROD_W'(wbase_reg);
    assign prod      = prod_full[MAG_W-1:0];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_mode_reg <= '0;
            max_width_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                itsu_pkg::REG_BASE_MODE: base_mode_reg <= wr_data[BASE_W-1:0];
                itsu_pkg::REG_MAX_WIDTH: max_width_reg <= wr_data[LIMIT_W-1:0];
                default:                 base_mode_reg <= base_mode_reg;
            endcase
        end
    end

    // One scan step on the registered word
    always_comb
    begin : scan_step
        logic                          have;
        logic [itsu_pkg::BYTE_W-1:0]   c;
        logic                          took;
        logic                          fin;
        logic [itsu_pkg::DIGIT_W-1:0]  d;
        logic                          room;

        have = !eoi_reg;
        c    = byte_reg;
        took = 1'b0;
        fin  = 1'b0;
        d    = itsu_pkg::NOT_A_DIGIT;
        room = 1'b0;

        phase_next = phase_reg;
        acc_next   = acc_reg;
        count_next = count_reg;
        wbase_next = wbase_reg;
        saw_next   = saw_reg;
        minus_next = minus_reg;

        // Skip blanks, take a sign
        if (phase_next == PH_SKIP)
        begin
            room = (max_width_reg == '0) || (count_next < max_width_reg);
            if (have && itsu_pkg::blank_byte(c))
            begin
                took = 1'b1;
            end
            else if (have && (c == itsu_pkg::CH_PLUS || c == itsu_pkg::CH_MINUS) && room)
            begin
                minus_next = (c == itsu_pkg::CH_MINUS);
                if (count_next != COUNT_MAX)
                    count_next = count_next + LIMIT_W'(1);
                phase_next = PH_PREFIX;
                took       = 1'b1;
            end
            else
            begin
                phase_next = PH_PREFIX;
            end
        end

        // Decide the base, take a leading zero
        if (!took && phase_next == PH_PREFIX)
        begin
            if (have && c == itsu_pkg::CH_ZERO &&
                (base_mode_reg == itsu_pkg::BASE_AUTO || base_mode_reg == itsu_pkg::BASE_HEX ||
                 base_mode_reg == itsu_pkg::BASE_BIN))
            begin
                wbase_next = base_mode_reg;
                saw_next   = 1'b1;
                if (count_next != COUNT_MAX)
                    count_next = count_next + LIMIT_W'(1);
                phase_next = PH_AFTER_ZERO;
                took       = 1'b1;
            end
            else
            begin
                wbase_next = (base_mode_reg == itsu_pkg::BASE_AUTO) ? itsu_pkg::BASE_DEC
                                                                    : base_mode_reg;
                phase_next = PH_DIGITS;
            end
        end

        // Take an x or b after the leading zero, or fall back to octal
        if (!took && phase_next == PH_AFTER_ZERO)
        begin
            if (have && (c == itsu_pkg::CH_LO_X || c == itsu_pkg::CH_UP_X) &&
                (wbase_next == itsu_pkg::BASE_AUTO || wbase_next == itsu_pkg::BASE_HEX))
            begin
                wbase_next = itsu_pkg::BASE_HEX;
                saw_next   = 1'b0;
                if (count_next != COUNT_MAX)
                    count_next = count_next + LIMIT_W'(1);
                took = 1'b1;
            end
            else if (have && (c == itsu_pkg::CH_LO_B || c == itsu_pkg::CH_UP_B) &&
                     wbase_next == itsu_pkg::BASE_AUTO)
            begin
                wbase_next = itsu_pkg::BASE_BIN;
                saw_next   = 1'b0;
                if (count_next != COUNT_MAX)
                    count_next = count_next + LIMIT_W'(1);
                took = 1'b1;
            end
            else if (wbase_next == itsu_pkg::BASE_AUTO)
            begin
                wbase_next = itsu_pkg::BASE_OCT;
            end
            phase_next = PH_DIGITS;
        end

        // Accumulate a digit or close the number
        if (!took && phase_next == PH_DIGITS)
        begin
            room = (max_width_reg == '0) || (count_next < max_width_reg);
            d    = have ? itsu_pkg::digit_value(c) : itsu_pkg::NOT_A_DIGIT;
            if (!have || !room || d >= itsu_pkg::DIGIT_W'(wbase_next))
            begin
                fin = 1'b1;
            end
            else
            begin
                acc_next = prod + MAG_W'(d);
                saw_next = 1'b1;
                if (count_next != COUNT_MAX)
                    count_next = count_next + LIMIT_W'(1);
                took = 1'b1;
            end
        end

        taken_next    = took;
        done_next     = fin;
        invalid_next  = fin && !saw_next;
        negative_next = fin && minus_next;
        mag_next      = fin ? acc_next : '0;

        // Start over after a finished number
        if (fin)
        begin
            phase_next = PH_SKIP;
            acc_next   = '0;
            count_next = '0;
            wbase_next = '0;
            saw_next   = 1'b0;
            minus_next = 1'b0;
        end
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            in_valid_reg <= text.valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (text.ready && text.valid)
        begin
            byte_reg <= text.byte_in;
            eoi_reg  <= text.end_of_input;
        end
    end

    // Scan state, advanced once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            acc_reg   <= '0;
            count_reg <= '0;
            wbase_reg <= '0;
            saw_reg   <= 1'b0;
            minus_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
            wbase_reg <= wbase_next;
            saw_reg   <= saw_next;
            minus_reg <= minus_next;
        end
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Output register payload, held while stalled
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            taken_reg    <= taken_next;
            done_reg     <= done_next;
            invalid_reg  <= invalid_next;
            negative_reg <= negative_next;
            mag_reg      <= mag_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.taken     = taken_reg;
    assign result.done_res  = done_reg;
    assign result.invalid   = invalid_reg;
    assign result.negative  = negative_reg;
    assign result.magnitude = mag_reg;

endmodule

/* test/tb_integer_text_scanner_unit.sv */
`timescale 1ns / 1ps

module tb_integer_text_scanner_unit;

    localparam int CYCLE_LIMIT = 200000;
    localparam int CALM_FROM   = 300;
    localparam int CALM_TO     = 900;
    localparam int FEED_SIDE   = 0;
    localparam int CHECK_SIDE  = 1;

    typedef enum logic [3:0] {
        SCAN_SKIP   = 4'b0001,
        SCAN_SIGNED = 4'b0010,
        SCAN_ZERO   = 4'b0100,
        SCAN_DIGITS = 4'b1000
    } scan_phase_t;

    typedef struct packed {
        scan_phase_t  phase;
        logic [63:0]  acc;
        logic [7:0]   count;
        logic [5:0]   base;
        logic         saw_digit;
        logic         minus;
    } scan_state_t;

    typedef struct packed {
        logic         taken;
        logic         done_res;
        logic         invalid;
        logic         negative;
        logic [63:0]  magnitude;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wr_en = 1'b0;
    logic [itsu_pkg::INDEX_W-1:0] wr_index = '0;
    logic [itsu_pkg::DATA_W-1:0] wr_data = '0;

    itsu_text_if   text_ch ();
    itsu_result_if result_ch ();

    integer_text_scanner_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Scanner state: one copy steers the feed, one follows accepted words
    scan_state_t track [2];
    logic [itsu_pkg::BASE_W-1:0] base_cfg = itsu_pkg::BASE_AUTO;
    logic [itsu_pkg::LIMIT_W-1:0] width_cfg = '0;

    logic [8:0] byte_feed [$];
    logic [8:0] draft [$];
    verdict_t owed_verdicts [$];
    int fed = 0;
    int fault_count = 0;
    int cycles = 0;
    logic text_moved = 1'b0;
    logic [8:0] next_word;
    verdict_t got_verdict;
    verdict_t want_verdict;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic is_blank(input logic [7:0] c);
        case (c)
            itsu_pkg::CH_SPACE, itsu_pkg::CH_TAB, itsu_pkg::CH_LF,
            itsu_pkg::CH_CR, itsu_pkg::CH_VT, itsu_pkg::CH_FF: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [6:0] char_value(input logic [7:0] c);
        if (c >= itsu_pkg::CH_ZERO && c <= itsu_pkg::CH_NINE)
        begin
            return 7'(c - itsu_pkg::CH_ZERO);
        end
        if (c >= itsu_pkg::CH_LO_A && c <= itsu_pkg::CH_LO_Z)
        begin
            return 7'(c - itsu_pkg::CH_LO_A) + 7'd10;
        end
        if (c >= itsu_pkg::CH_UP_A && c <= itsu_pkg::CH_UP_Z)
        begin
            return 7'(c - itsu_pkg::CH_UP_A) + 7'd10;
        end
        return itsu_pkg::NOT_A_DIGIT;
    endfunction

    function automatic logic [7:0] sat_inc(input logic [7:0] n);
        return (n == 8'hff) ? n : n + 8'd1;
    endfunction

    // Advance one scanner copy by one word and return the verdict it gives
    function automatic verdict_t scan_byte(input int who, input logic [7:0] c, input logic eoi,
                                           input logic [5:0] bmode, input logic [7:0] wlim);
        scan_state_t s;
        verdict_t v;
        logic have;
        logic took;
        logic fin;
        logic [6:0] d;
        s = track[who];
        v = '0;
        have = !eoi;
        took = 1'b0;
        fin = 1'b0;

        // Skip blanks, take an optional sign
        if (s.phase == SCAN_SKIP)
        begin
            if (have && is_blank(c))
            begin
                took = 1'b1;
            end
            else if (have && (c == itsu_pkg::CH_PLUS || c == itsu_pkg::CH_MINUS) &&
                     (wlim == 0 || s.count < wlim))
            begin
                s.minus = (c == itsu_pkg::CH_MINUS);
                s.count = sat_inc(s.count);
                s.phase = SCAN_SIGNED;
                took = 1'b1;
            end
            else
            begin
                s.phase = SCAN_SIGNED;
            end
        end

        // Sample the base; a leading zero may open a prefix
        if (!took && s.phase == SCAN_SIGNED)
        begin
            if (have && c == itsu_pkg::CH_ZERO &&
                (bmode == itsu_pkg::BASE_AUTO || bmode == itsu_pkg::BASE_HEX ||
                 bmode == itsu_pkg::BASE_BIN))
            begin
                s.base = bmode;
                s.saw_digit = 1'b1;
                s.count = sat_inc(s.count);
                s.phase = SCAN_ZERO;
                took = 1'b1;
            end
            else
            begin
                s.base = (bmode == itsu_pkg::BASE_AUTO) ? itsu_pkg::BASE_DEC : bmode;
                s.phase = SCAN_DIGITS;
            end
        end

        // Resolve x / b after the zero, or fall back to octal
        if (!took && s.phase == SCAN_ZERO)
        begin
            if (have && (c == itsu_pkg::CH_LO_X || c == itsu_pkg::CH_UP_X) &&
                (s.base == itsu_pkg::BASE_AUTO || s.base == itsu_pkg::BASE_HEX))
            begin
                s.base = itsu_pkg::BASE_HEX;
                s.saw_digit = 1'b0;
                s.count = sat_inc(s.count);
                took = 1'b1;
            end
            else if (have && (c == itsu_pkg::CH_LO_B || c == itsu_pkg::CH_UP_B) &&
                     s.base == itsu_pkg::BASE_AUTO)
            begin
                s.base = itsu_pkg::BASE_BIN;
                s.saw_digit = 1'b0;
                s.count = sat_inc(s.count);
                took = 1'b1;
            end
            else if (s.base == itsu_pkg::BASE_AUTO)
            begin
                s.base = itsu_pkg::BASE_OCT;
            end
            s.phase = SCAN_DIGITS;
        end

        // Accumulate digits until one is refused
        if (!took && s.phase == SCAN_DIGITS)
        begin
            d = have ? char_value(c) : itsu_pkg::NOT_A_DIGIT;
            if (!have || !(wlim == 0 || s.count < wlim) || d >= {1'b0, s.base})
            begin
                fin = 1'b1;
            end
            else
            begin
                s.acc = s.acc * 64'(s.base) + 64'(d);
                s.saw_digit = 1'b1;
                s.count = sat_inc(s.count);
                took = 1'b1;
            end
        end

        v.taken = took;
        v.done_res = fin;
        if (fin)
        begin
            v.invalid = !s.saw_digit;
            v.negative = s.minus;
            v.magnitude = s.acc;
            s = '0;
            s.phase = SCAN_SKIP;
        end
        track[who] = s;
        return v;
    endfunction

    function automatic logic quiet();
        if (cycles >= CALM_FROM && cycles < CALM_TO)
        begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 10;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fault_count++;
        end
    endtask

    // Present words; hold a word until it is accepted, and drive result ready at random
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!text_ch.valid || text_moved)
            begin
                if (byte_feed.size() != 0 && !quiet())
                begin
                    next_word = byte_feed.pop_front();
                    text_ch.valid <= 1'b1;
                    text_ch.byte_in <= next_word[7:0];
                    text_ch.end_of_input <= next_word[8];
                end
                else
                begin
                    text_ch.valid <= 1'b0;
                end
            end
            result_ch.ready <= !quiet();
        end
    end

    // Check results against the oldest owed verdict, then log accepted words
    always @(posedge clk)
    begin
        text_moved = 1'b0;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got_verdict.taken = result_ch.taken;
                got_verdict.done_res = result_ch.done_res;
                got_verdict.invalid = result_ch.invalid;
                got_verdict.negative = result_ch.negative;
                got_verdict.magnitude = result_ch.magnitude;
                if (owed_verdicts.size() == 0)
                begin
                    $error("result word with no verdict owed");
                    fault_count++;
                end
                else
                begin
                    want_verdict = owed_verdicts.pop_front();
                    check_field("taken", 64'(want_verdict.taken), 64'(got_verdict.taken));
                    check_field("done_res", 64'(want_verdict.done_res),
                                64'(got_verdict.done_res));
                    check_field("invalid", 64'(want_verdict.invalid), 64'(got_verdict.invalid));
                    check_field("negative", 64'(want_verdict.negative),
                                64'(got_verdict.negative));
                    check_field("magnitude", want_verdict.magnitude, got_verdict.magnitude);
                end
            end
            text_moved = text_ch.valid && text_ch.ready;
            if (text_moved)
            begin
                owed_verdicts.push_back(scan_byte(CHECK_SIDE, text_ch.byte_in,
                                                  text_ch.end_of_input, base_cfg, width_cfg));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic add(input logic [7:0] b);
        draft.push_back({1'b0, b});
    endtask

    task automatic add_end();
        draft.push_back({1'b1, 8'($urandom_range(0, 255))});
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0: return itsu_pkg::CH_SPACE;
            1: return itsu_pkg::CH_TAB;
            2: return itsu_pkg::CH_LF;
            3: return itsu_pkg::CH_CR;
            4: return itsu_pkg::CH_VT;
            default: return itsu_pkg::CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] digit_char(input int v);
        if (v < 10)
        begin
            return itsu_pkg::CH_ZERO + 8'(v);
        end
        return ($urandom_range(0, 1) ? itsu_pkg::CH_LO_A : itsu_pkg::CH_UP_A) + 8'(v - 10);
    endfunction

    // Move the draft into the feed; a refused byte is offered at most once more
    task automatic feed_draft();
        int k;
        int tries;
        verdict_t v;
        k = 0;
        tries = 0;
        while (k < draft.size())
        begin
            byte_feed.push_back(draft[k]);
            fed++;
            v = scan_byte(FEED_SIDE, draft[k][7:0], draft[k][8], base_cfg, width_cfg);
            if (v.taken || tries == 1 || $urandom_range(0, 19) == 0)
            begin
                k++;
                tries = 0;
            end
            else
            begin
                tries++;
            end
        end
        draft.delete();
    endtask

    // Well-formed number with random content and a random terminator
    task automatic draft_number();
        int n;
        int top;
        logic [5:0] eff;
        repeat ($urandom_range(0, 3)) add(pick_blank());
        case ($urandom_range(0, 3))
            1: add(itsu_pkg::CH_PLUS);
            2: add(itsu_pkg::CH_MINUS);
            default: ;
        endcase
        eff = base_cfg;
        if (base_cfg == itsu_pkg::BASE_AUTO)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    add(itsu_pkg::CH_ZERO);
                    add($urandom_range(0, 1) ? itsu_pkg::CH_LO_X : itsu_pkg::CH_UP_X);
                    eff = itsu_pkg::BASE_HEX;
                end
                1:
                begin
                    add(itsu_pkg::CH_ZERO);
                    add($urandom_range(0, 1) ? itsu_pkg::CH_LO_B : itsu_pkg::CH_UP_B);
                    eff = itsu_pkg::BASE_BIN;
                end
                2:
                begin
                    add(itsu_pkg::CH_ZERO);
                    eff = itsu_pkg::BASE_OCT;
                end
                default: eff = itsu_pkg::BASE_DEC;
            endcase
        end
        else if (base_cfg == itsu_pkg::BASE_HEX && $urandom_range(0, 1))
        begin
            add(itsu_pkg::CH_ZERO);
            add($urandom_range(0, 1) ? itsu_pkg::CH_LO_X : itsu_pkg::CH_UP_X);
        end
        top = (eff > 36) ? 36 : int'(eff);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
        repeat (n) add(digit_char($urandom_range(0, top - 1)));
        case ($urandom_range(0, 3))
            0: add_end();
            1: add(pick_blank());
            2: add(8'($urandom_range(0, 255)));
            default: add(digit_char($urandom_range(0, 35)));
        endcase
    endtask

    // Broken sequences and plain noise
    task automatic draft_junk();
        case ($urandom_range(0, 4))
            0:
            begin
                add(itsu_pkg::CH_ZERO);
                add($urandom_range(0, 1) ? itsu_pkg::CH_LO_X : itsu_pkg::CH_LO_B);
                if ($urandom_range(0, 1))
                begin
                    add_end();
                end
                else
                begin
                    add(8'($urandom_range(0, 255)));
                end
            end
            1:
            begin
                add($urandom_range(0, 1) ? itsu_pkg::CH_PLUS : itsu_pkg::CH_MINUS);
                if ($urandom_range(0, 1))
                begin
                    add_end();
                end
                else
                begin
                    add(pick_blank());
                end
            end
            2:
            begin
                add(itsu_pkg::CH_PLUS);
                add(itsu_pkg::CH_MINUS);
                add(digit_char($urandom_range(0, 9)));
            end
            3: add_end();
            default:
            begin
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        add_end();
                    end
                    else
                    begin
                        add(8'($urandom_range(0, 255)));
                    end
                end
            end
        endcase
    endtask

    // Long decimal run: saturates the character count and wraps the value
    task automatic draft_long(input int len);
        add(itsu_pkg::CH_MINUS);
        repeat (len) add(digit_char($urandom_range(0, 9)));
        add_end();
    endtask

    task automatic write_reg(input logic [itsu_pkg::INDEX_W-1:0] idx,
                             input logic [itsu_pkg::DATA_W-1:0] val);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(negedge clk);
        wr_en <= 1'b0;
        if (idx == itsu_pkg::REG_BASE_MODE)
        begin
            base_cfg = val[itsu_pkg::BASE_W-1:0];
        end
        else
        begin
            width_cfg = val;
        end
    endtask

    // Wait until every word is accepted and every verdict has come back
    task automatic drain();
        while (byte_feed.size() != 0 || text_ch.valid || owed_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input logic [5:0] b, input logic [7:0] w, input int items,
                             input int long_len);
        int start;
        write_reg(itsu_pkg::REG_BASE_MODE, itsu_pkg::DATA_W'(b));
        write_reg(itsu_pkg::REG_MAX_WIDTH, w);
        if (long_len > 0)
        begin
            draft_long(long_len);
            feed_draft();
        end
        start = fed;
        while (fed - start < items)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                draft_number();
            end
            else
            begin
                draft_junk();
            end
            feed_draft();
        end
        drain();
    endtask

    initial
    begin
        track[FEED_SIDE] = '0;
        track[FEED_SIDE].phase = SCAN_SKIP;
        track[CHECK_SIDE] = '0;
        track[CHECK_SIDE].phase = SCAN_SKIP;
        text_ch.valid = 1'b0;
        text_ch.byte_in = '0;
        text_ch.end_of_input = 1'b0;
        result_ch.ready = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every blank, signed hex, empty binary prefix, lone sign,
        // octal cut short by a digit out of base
        add(itsu_pkg::CH_TAB);
        add(itsu_pkg::CH_LF);
        add(itsu_pkg::CH_VT);
        add(itsu_pkg::CH_FF);
        add(itsu_pkg::CH_CR);
        add(itsu_pkg::CH_SPACE);
        add(itsu_pkg::CH_MINUS);
        add(itsu_pkg::CH_ZERO);
        add(itsu_pkg::CH_UP_X);
        add(itsu_pkg::CH_LO_A + 8'd5);
        add_end();
        add(itsu_pkg::CH_ZERO);
        add(itsu_pkg::CH_LO_B);
        add(itsu_pkg::CH_SPACE);
        add(itsu_pkg::CH_PLUS);
        add_end();
        add(itsu_pkg::CH_ZERO);
        add(itsu_pkg::CH_ZERO + 8'd7);
        add(itsu_pkg::CH_NINE);
        add_end();
        feed_draft();
        drain();

        // Random phases over many settings, extremes included
        run_phase(itsu_pkg::BASE_DEC, 8'd0, 35, 280);
        run_phase(itsu_pkg::BASE_HEX, 8'd0, 45, 0);
        run_phase(itsu_pkg::BASE_BIN, 8'd0, 35, 0);
        run_phase(itsu_pkg::BASE_OCT, 8'd0, 35, 0);
        run_phase(6'd36, 8'd0, 45, 0);
        run_phase(6'd1, 8'd0, 35, 0);
        run_phase(6'd63, 8'd0, 35, 0);
        run_phase(6'd37, 8'd0, 35, 0);
        run_phase(itsu_pkg::BASE_AUTO, 8'd1, 35, 0);
        run_phase(itsu_pkg::BASE_AUTO, 8'd2, 35, 0);
        run_phase(itsu_pkg::BASE_HEX, 8'd3, 35, 0);
        run_phase(itsu_pkg::BASE_DEC, 8'd5, 35, 0);
        run_phase(itsu_pkg::BASE_AUTO, 8'd255, 45, 270);
        repeat (4)
        begin
            run_phase(6'($urandom_range(0, 63)), 8'($urandom_range(0, 12)), 35, 0);
        end
        run_phase(itsu_pkg::BASE_AUTO, 8'd0, 60, 0);

        repeat (6) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/itsu_pkg.sv
src/itsu_if.sv
src/integer_text_scanner_unit.sv
test/tb_integer_text_scanner_unit.sv
